// File: hw/rtl/swmg_pkg.sv
// ----------------------------------------------------------------------------
// swmg_pkg: shared types and constants
// Register indexes, CORDIC tables, channel payloads and controller command types.
// ----------------------------------------------------------------------------
package swmg_pkg;

  localparam int unsigned CordicSteps = 24;
  localparam int unsigned IterW = $clog2(CordicSteps + 1);
  localparam int unsigned NumRegs = 6;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] RegAmpX  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegAmpY  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegAmpZ  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegFreqX = 3'd3;
  localparam logic [CfgIdxW-1:0] RegFreqY = 3'd4;
  localparam logic [CfgIdxW-1:0] RegFreqZ = 3'd5;

  localparam logic signed [33:0] GainQ30 = 34'sd652032874;
  localparam logic [31:0] TwoPiQ29 = 32'd3373259426;

  // input item: one time step
  typedef struct packed {
    logic [31:0] time_step;
  } in_item_t;

  // register write item: index above value
  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [31:0]        value;
  } cfg_item_t;

  // result item, offsets first
  typedef struct packed {
    logic [31:0] offset_x;
    logic [31:0] offset_y;
    logic [31:0] offset_z;
    logic [31:0] speed_x;
    logic [31:0] speed_y;
    logic [31:0] speed_z;
  } out_item_t;

  function automatic logic [29:0] angle_lut(input logic [4:0] i);
    logic [29:0] r;
    unique case (i)
      5'd0:  r = 30'd536870912;
      5'd1:  r = 30'd316933406;
      5'd2:  r = 30'd167458907;
      5'd3:  r = 30'd85004756;
      5'd4:  r = 30'd42667331;
      5'd5:  r = 30'd21354465;
      5'd6:  r = 30'd10679838;
      5'd7:  r = 30'd5340245;
      5'd8:  r = 30'd2670163;
      5'd9:  r = 30'd1335087;
      5'd10: r = 30'd667544;
      5'd11: r = 30'd333772;
      5'd12: r = 30'd166886;
      5'd13: r = 30'd83443;
      5'd14: r = 30'd41722;
      5'd15: r = 30'd20861;
      5'd16: r = 30'd10430;
      5'd17: r = 30'd5215;
      5'd18: r = 30'd2608;
      5'd19: r = 30'd1304;
      5'd20: r = 30'd652;
      5'd21: r = 30'd326;
      5'd22: r = 30'd163;
      5'd23: r = 30'd81;
      5'd24: r = 30'd41;
      5'd25: r = 30'd20;
      5'd26: r = 30'd10;
      5'd27: r = 30'd5;
      5'd28: r = 30'd3;
      5'd29: r = 30'd1;
      5'd30: r = 30'd1;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

  typedef enum logic [8:0] {
    StIdle  = 9'b000000001,
    StAdv   = 9'b000000010,
    StInit  = 9'b000000100,
    StIter  = 9'b000001000,
    StQuad  = 9'b000010000,
    StMul1  = 9'b000100000,
    StMul2  = 9'b001000000,
    StRound = 9'b010000000,
    StOut   = 9'b100000000
  } state_e;

  typedef struct packed {
    logic       load;
    logic       adv;
    logic       init;
    logic       iter;
    logic       quad;
    logic       mul1;
    logic       mul2;
    logic       round;
    logic       out_load;
    logic [1:0] axis;
  } cmd_t;

endpackage

// File: hw/rtl/swmg_stream_if.sv
// ----------------------------------------------------------------------------
// swmg_stream_if: valid/ready channel
// Generic handshake channel carrying a payload of parametric type.
// ----------------------------------------------------------------------------
interface swmg_stream_if #(parameter type payload_t = logic [31:0]);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/swmg_ctrl.sv
// ----------------------------------------------------------------------------
// swmg_ctrl: sequencer
// Steps each item through phase advance and three axes of CORDIC and scaling.
// ----------------------------------------------------------------------------
module swmg_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 out_busy_i,
  output swmg_pkg::cmd_t       cmd_o,
  output logic [swmg_pkg::IterW-1:0] iter_o
);
  swmg_pkg::state_e state_q, state_d;
  logic [1:0] axis_q, axis_d;
  logic [swmg_pkg::IterW-1:0] iter_q, iter_d;

  assign in_ready_o = (state_q == swmg_pkg::StIdle);
  assign iter_o = iter_q;

  always_comb begin
    state_d = state_q;
    axis_d = axis_q;
    iter_d = iter_q;
    cmd_o = '0;
    cmd_o.axis = axis_q;
    unique case (state_q)
      swmg_pkg::StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = swmg_pkg::StAdv;
        end
      end
      swmg_pkg::StAdv: begin
        cmd_o.adv = 1'b1;
        axis_d = 2'd0;
        state_d = swmg_pkg::StInit;
      end
      swmg_pkg::StInit: begin
        cmd_o.init = 1'b1;
        iter_d = '0;
        state_d = swmg_pkg::StIter;
      end
      swmg_pkg::StIter: begin
        cmd_o.iter = 1'b1;
        iter_d = iter_q + 1'b1;
        if (iter_q == swmg_pkg::IterW'(swmg_pkg::CordicSteps - 1)) begin
          state_d = swmg_pkg::StQuad;
        end
      end
      swmg_pkg::StQuad: begin
        cmd_o.quad = 1'b1;
        state_d = swmg_pkg::StMul1;
      end
      swmg_pkg::StMul1: begin
        cmd_o.mul1 = 1'b1;
        iter_d = '0;
        state_d = swmg_pkg::StMul2;
      end
      // low then high half of the velocity product
      swmg_pkg::StMul2: begin
        cmd_o.mul2 = 1'b1;
        iter_d = iter_q + 1'b1;
        if (iter_q[0]) begin
          state_d = swmg_pkg::StRound;
        end
      end
      swmg_pkg::StRound: begin
        cmd_o.round = 1'b1;
        if (axis_q == 2'd2) begin
          state_d = swmg_pkg::StOut;
        end else begin
          axis_d = axis_q + 2'd1;
          state_d = swmg_pkg::StInit;
        end
      end
      swmg_pkg::StOut: begin
        if (!out_busy_i) begin
          cmd_o.out_load = 1'b1;
          state_d = swmg_pkg::StIdle;
        end
      end
      default: state_d = swmg_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= swmg_pkg::StIdle;
      axis_q <= '0;
      iter_q <= '0;
    end else begin
      state_q <= state_d;
      axis_q <= axis_d;
      iter_q <= iter_d;
    end
  end
endmodule

// File: hw/rtl/swmg_datapath.sv
// ----------------------------------------------------------------------------
// swmg_datapath: phase, CORDIC and scaling arithmetic
// One shared CORDIC and one shared multiply chain serve the three axes.
// ----------------------------------------------------------------------------
module swmg_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  swmg_pkg::cmd_t       cmd_i,
  input  logic [swmg_pkg::IterW-1:0] iter_i,
  input  logic [31:0]          time_step_i,
  input  logic                 cfg_we_i,
  input  logic [swmg_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [31:0]          cfg_data_i,
  output logic [31:0]          pos_o [3],
  output logic [31:0]          vel_o [3]
);
  logic [31:0] amp_q [3];
  logic [31:0] freq_q [3];
  logic [31:0] phase_q [3];
  logic signed [33:0] cx_q, cy_q;
  logic signed [31:0] cz_q;
  logic signed [31:0] s_q, c_q;
  logic [34:0] omega_q;
  logic [63:0] inc_q [3];
  logic signed [63:0] ps_q;
  logic signed [63:0] ac_q;
  logic [99:0] pv_q;
  logic [31:0] pos_q [3];
  logic [31:0] vel_q [3];
  logic [31:0] amp, freq;
  logic [1:0] quad;
  logic [4:0] ii;
  logic [63:0] ps_mag, ac_mag;
  logic [66:0] pp;

  assign amp = amp_q[cmd_i.axis];
  assign freq = freq_q[cmd_i.axis];
  assign quad = phase_q[cmd_i.axis][31:30];
  assign ii = 5'(iter_i);

  assign ps_mag = ps_q[63] ? 64'(-ps_q) : 64'(ps_q);
  assign ac_mag = ac_q[63] ? 64'(-ac_q) : 64'(ac_q);

  // one 32x35 partial product per cycle, low half of |amp*cos| first
  assign pp = {35'd0, (iter_i[0] ? ac_mag[63:32] : ac_mag[31:0])} * {32'd0, omega_q};

  // round half away from zero of mag / 2^sh, apply sign, saturate to 32 bits
  function automatic logic [31:0] rnd_sat(input logic [99:0] mag, input logic neg,
                                          input int unsigned sh);
    logic [99:0] q;
    q = (mag + (100'd1 << (sh - 1))) >> sh;
    if (neg) begin
      if (q > 100'h8000_0000) q = 100'h8000_0000;
      return 32'd0 - q[31:0];
    end
    if (q > 100'h7FFF_FFFF) q = 100'h7FFF_FFFF;
    return q[31:0];
  endfunction

  // configuration registers and phase accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        amp_q[k] <= '0;
        freq_q[k] <= '0;
        phase_q[k] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          swmg_pkg::RegAmpX:  amp_q[0] <= cfg_data_i;
          swmg_pkg::RegAmpY:  amp_q[1] <= cfg_data_i;
          swmg_pkg::RegAmpZ:  amp_q[2] <= cfg_data_i;
          swmg_pkg::RegFreqX: freq_q[0] <= cfg_data_i;
          swmg_pkg::RegFreqY: freq_q[1] <= cfg_data_i;
          swmg_pkg::RegFreqZ: freq_q[2] <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.adv) begin
        for (int k = 0; k < 3; k++) begin
          phase_q[k] <= phase_q[k] + inc_q[k][47:16];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    // phase increments of the accepted step
    if (cmd_i.load) begin
      for (int k = 0; k < 3; k++) begin
        inc_q[k] <= {32'd0, freq_q[k]} * {32'd0, time_step_i};
      end
    end
    if (cmd_i.init) begin
      cx_q <= swmg_pkg::GainQ30;
      cy_q <= '0;
      cz_q <= {2'b00, phase_q[cmd_i.axis][29:0]};
      omega_q <= 35'(({32'd0, freq} * {32'd0, swmg_pkg::TwoPiQ29} + 64'd268435456) >> 29);
    end
    if (cmd_i.iter) begin
      if (!cz_q[31]) begin
        cx_q <= cx_q - (cy_q >>> iter_i);
        cy_q <= cy_q + (cx_q >>> iter_i);
        cz_q <= cz_q - $signed({2'b00, swmg_pkg::angle_lut(ii)});
      end else begin
        cx_q <= cx_q + (cy_q >>> iter_i);
        cy_q <= cy_q - (cx_q >>> iter_i);
        cz_q <= cz_q + $signed({2'b00, swmg_pkg::angle_lut(ii)});
      end
    end
    if (cmd_i.quad) begin
      unique case (quad)
        2'd0: begin s_q <= 32'(cy_q);  c_q <= 32'(cx_q);  end
        2'd1: begin s_q <= 32'(cx_q);  c_q <= 32'(-cy_q); end
        2'd2: begin s_q <= 32'(-cy_q); c_q <= 32'(-cx_q); end
        default: begin s_q <= 32'(-cx_q); c_q <= 32'(cy_q); end
      endcase
    end
    if (cmd_i.mul1) begin
      ps_q <= $signed(amp) * s_q;
      ac_q <= $signed(amp) * c_q;
    end
    if (cmd_i.mul2) begin
      if (!iter_i[0]) begin
        pv_q <= {33'd0, pp};
      end else begin
        pv_q <= pv_q + {1'b0, pp, 32'd0};
      end
    end
    if (cmd_i.round) begin
      pos_q[cmd_i.axis] <= rnd_sat({36'd0, ps_mag}, ps_q[63], 30);
      vel_q[cmd_i.axis] <= rnd_sat(pv_q, ac_q[63], 46);
    end
  end

  assign pos_o = pos_q;
  assign vel_o = vel_q;
endmodule

// File: hw/rtl/sinusoidal_wall_motion_generator.sv
// ----------------------------------------------------------------------------
// sinusoidal_wall_motion_generator: three-axis sine position/velocity source
// Phase accumulators, shared CORDIC and saturating Q16.16 scaling.
// ----------------------------------------------------------------------------
// Each accepted item is one time step: all three phases advance by
// frequency*time_step, then each axis runs the shared 24-step CORDIC and the
// shared multiply chain in turn. The steps from the accepting cycle to the
// result register are: accept, phase advance, per axis load, 24 iterations,
// quadrant, product, low and high halves of the velocity product and
// rounding, then the output load. The result waits in an output register;
// the next item is taken once the result has moved there, so a stalled
// receiver holds the input off.
// Configuration writes are taken at any time but are meant only while idle;
// writes to unknown indexes are dropped.
module sinusoidal_wall_motion_generator (
  input  logic clk_i,
  input  logic rst_ni,
  swmg_stream_if.sink   in_if,
  swmg_stream_if.sink   cfg_if,
  swmg_stream_if.source out_if
);
  swmg_pkg::cmd_t cmd;
  logic [swmg_pkg::IterW-1:0] iter;
  logic [31:0] pos [3];
  logic [31:0] vel [3];
  logic out_valid_q;

  // config payload: {index, value}
  assign cfg_if.ready = 1'b1;

  swmg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .out_busy_i (out_valid_q && !out_if.ready),
    .cmd_o      (cmd),
    .iter_o     (iter)
  );

  swmg_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .iter_i      (iter),
    .time_step_i (in_if.data.time_step),
    .cfg_we_i    (cfg_if.valid),
    .cfg_idx_i   (cfg_if.data.index),
    .cfg_data_i  (cfg_if.data.value),
    .pos_o       (pos),
    .vel_o       (vel)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.out_load) begin
      out_if.data.offset_x <= pos[0];
      out_if.data.offset_y <= pos[1];
      out_if.data.offset_z <= pos[2];
      out_if.data.speed_x  <= vel[0];
      out_if.data.speed_y  <= vel[1];
      out_if.data.speed_z  <= vel[2];
    end
  end

  assign out_if.valid = out_valid_q;
endmodule
